/* sv/acs_pkg.sv */
// Shared types, codes and helpers for the advertising channel event sequencer.
package acs_pkg;

    localparam int unsigned MAX_DELAY_US     = 10000;
    localparam int unsigned INTERVAL_UNIT_US = 625;

    localparam int unsigned MOD_STEPS = $clog2(65535 / MAX_DELAY_US + 1);
    localparam int unsigned MOD_CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam logic [31:0] DELAY_DIV = 32'(MAX_DELAY_US);
    localparam logic [31:0] UNIT_MULT = 32'(INTERVAL_UNIT_US);

    localparam int unsigned NUM_CFG    = 7;
    localparam int unsigned CFG_ADDR_W = $clog2(NUM_CFG * 4);

    localparam logic [5:0]  FIRST_ADV_CH = 6'd37;
    localparam logic [15:0] LFSR_SEED    = 16'hACE1;

    localparam logic [1:0] REQ_SET_PARAMS = 2'd0;
    localparam logic [1:0] REQ_ENABLE     = 2'd1;
    localparam logic [1:0] REQ_TX_DONE    = 2'd2;

    localparam logic [1:0] STS_SUCCESS    = 2'd0;
    localparam logic [1:0] STS_DISALLOWED = 2'd1;
    localparam logic [1:0] STS_INVALID    = 2'd2;

    localparam logic [7:0] KIND_IND       = 8'd0;
    localparam logic [7:0] KIND_DIRECT_HD = 8'd1;
    localparam logic [7:0] KIND_SCAN_IND  = 8'd2;
    localparam logic [7:0] KIND_NONCONN   = 8'd3;
    localparam logic [7:0] KIND_DIRECT_LD = 8'd4;

    localparam logic [7:0] ENABLE_OFF = 8'd0;
    localparam logic [7:0] ENABLE_ON  = 8'd1;

    localparam logic [7:0] OWN_ADDR_MAX  = 8'd3;
    localparam logic [7:0] PEER_ADDR_MAX = 8'd1;
    localparam logic [7:0] FILTER_MAX    = 8'd3;
    localparam logic [7:0] MASK_RSVD     = 8'hF8;

    typedef enum logic [2:0] {
        CFG_CONN_FLOOR    = 3'd0,
        CFG_NONCONN_FLOOR = 3'd1,
        CFG_CEILING       = 3'd2,
        CFG_HD_GAP        = 3'd3,
        CFG_LD_GAP        = 3'd4,
        CFG_TX_LEAD       = 3'd5,
        CFG_EVENT_WINDOW  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] conn_interval_floor;
        logic [15:0] nonconn_interval_floor;
        logic [15:0] interval_ceiling;
        logic [15:0] high_duty_gap_us;
        logic [15:0] low_duty_gap_us;
        logic [15:0] tx_lead_us;
        logic [15:0] event_window_us;
    } acs_cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] interval_min;
        logic [15:0] interval_max;
        logic [7:0]  adv_kind;
        logic [7:0]  own_address_kind;
        logic [7:0]  peer_address_kind;
        logic [7:0]  channel_mask_in;
        logic [7:0]  filter_policy;
        logic [7:0]  enable_code;
        logic [31:0] now_time;
    } acs_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        sched_valid;
        logic [5:0]  channel;
        logic [31:0] slot_start;
        logic [31:0] slot_end;
        logic        listen_after_tx;
        logic        was_late;
    } acs_rsp_t;

    typedef struct packed {
        logic                 load_in;
        logic                 exec;
        logic                 rand_load;
        logic                 mod_step;
        logic [MOD_CNT_W-1:0] mod_shift;
        logic                 step_calc;
        logic                 advance;
        logic                 check;
        logic                 slot_calc;
        logic                 emit;
    } acs_cmd_t;

    typedef struct packed {
        logic need_step;
        logic hop;
        logic slot;
        logic late;
        logic diff_neg;
        logic delta_neg;
    } acs_stat_t;

    function automatic logic [5:0] first_channel(input logic [2:0] mask);
        logic [5:0] ch;
        if (mask[0])
            ch = FIRST_ADV_CH;
        else if (mask[1])
            ch = FIRST_ADV_CH + 6'd1;
        else
            ch = FIRST_ADV_CH + 6'd2;
        return ch;
    endfunction

    function automatic logic [5:0] last_channel(input logic [2:0] mask);
        logic [5:0] ch;
        if (mask[2])
            ch = FIRST_ADV_CH + 6'd2;
        else if (mask[1])
            ch = FIRST_ADV_CH + 6'd1;
        else
            ch = FIRST_ADV_CH;
        return ch;
    endfunction

    function automatic logic [15:0] lfsr_step(input logic [15:0] l);
        logic b;
        b = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {b, l[15:1]};
    endfunction

endpackage

/* sv/adv_channel_event_sequencer.sv */
// A command passes through EXEC and EMIT; a first slot adds SLOT, and a hop adds CHECK and SLOT.
// A new event adds RAND, the MOD_STEPS delay-reduction steps in MOD (3 at 10000 us), STEP and ADV.
// Each skipped late event runs these steps again, through the shared delay and adder path.
// A new request is taken only once the last result is emitted; results wait in an output register.
// Reset (rst_n low, async): disabled, no parameters, channel 37, LFSR 0xACE1, regs default.
module adv_channel_event_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  acs_pkg::acs_req_t              req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output acs_pkg::acs_rsp_t              rsp_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [acs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import acs_pkg::*;

    acs_cfg_t  cfg;
    acs_cmd_t  cmd;
    acs_stat_t stat;

    acs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    acs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    acs_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req_data (req_data),
        .rsp_data (rsp_data),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

/* sv/acs_cfg.sv */
// APB-style register file for the sequencer timing registers.
module acs_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [acs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output acs_pkg::acs_cfg_t              cfg
);
    import acs_pkg::*;

    acs_cfg_t cfg_reg;
    acs_cfg_t cfg_next;
    cfg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                CFG_CONN_FLOOR:    cfg_next.conn_interval_floor    = pwdata[15:0];
                CFG_NONCONN_FLOOR: cfg_next.nonconn_interval_floor = pwdata[15:0];
                CFG_CEILING:       cfg_next.interval_ceiling       = pwdata[15:0];
                CFG_HD_GAP:        cfg_next.high_duty_gap_us       = pwdata[15:0];
                CFG_LD_GAP:        cfg_next.low_duty_gap_us        = pwdata[15:0];
                CFG_TX_LEAD:       cfg_next.tx_lead_us             = pwdata[15:0];
                CFG_EVENT_WINDOW:  cfg_next.event_window_us        = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            CFG_CONN_FLOOR:    prdata = {16'd0, cfg_reg.conn_interval_floor};
            CFG_NONCONN_FLOOR: prdata = {16'd0, cfg_reg.nonconn_interval_floor};
            CFG_CEILING:       prdata = {16'd0, cfg_reg.interval_ceiling};
            CFG_HD_GAP:        prdata = {16'd0, cfg_reg.high_duty_gap_us};
            CFG_LD_GAP:        prdata = {16'd0, cfg_reg.low_duty_gap_us};
            CFG_TX_LEAD:       prdata = {16'd0, cfg_reg.tx_lead_us};
            CFG_EVENT_WINDOW:  prdata = {16'd0, cfg_reg.event_window_us};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conn_interval_floor    <= 16'd32;
            cfg_reg.nonconn_interval_floor <= 16'd160;
            cfg_reg.interval_ceiling       <= 16'd16384;
            cfg_reg.high_duty_gap_us       <= 16'd5000;
            cfg_reg.low_duty_gap_us        <= 16'd10000;
            cfg_reg.tx_lead_us             <= 16'd0;
            cfg_reg.event_window_us        <= 16'd1228;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* sv/acs_ctrl.sv */
// Sequencer controller: request handshake, step sequencing and result beat.
module acs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  acs_pkg::acs_stat_t stat,
    output acs_pkg::acs_cmd_t  cmd
);
    import acs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RAND,
        S_MOD,
        S_STEP,
        S_ADV,
        S_CHECK,
        S_SLOT,
        S_EMIT
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [MOD_CNT_W-1:0] mod_cnt_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 emit_go;

    assign emit_go   = (state_reg == S_EMIT) && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.load_in   = (state_reg == S_IDLE) && req_valid;
        cmd.exec      = (state_reg == S_EXEC);
        cmd.rand_load = (state_reg == S_RAND);
        cmd.mod_step  = (state_reg == S_MOD);
        cmd.mod_shift = mod_cnt_reg;
        cmd.step_calc = (state_reg == S_STEP);
        cmd.advance   = (state_reg == S_ADV);
        cmd.check     = (state_reg == S_CHECK);
        cmd.slot_calc = (state_reg == S_SLOT);
        cmd.emit      = emit_go;
    end

    always_comb
    begin
        state_next   = state_reg;
        mod_cnt_next = mod_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.need_step)
                    state_next = S_RAND;
                else if (stat.hop)
                    state_next = S_CHECK;
                else if (stat.slot)
                    state_next = S_SLOT;
                else
                    state_next = S_EMIT;
            end
            S_RAND:
            begin
                mod_cnt_next = MOD_CNT_W'(MOD_STEPS - 1);
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                if (mod_cnt_reg == '0)
                    state_next = S_STEP;
                else
                    mod_cnt_next = mod_cnt_reg - 1'b1;
            end
            S_STEP:
            begin
                state_next = S_ADV;
            end
            S_ADV:
            begin
                if (!stat.late)
                    state_next = S_CHECK;
                else if (stat.delta_neg)
                    state_next = S_RAND;
                else
                    state_next = S_SLOT;
            end
            S_CHECK:
            begin
                state_next = stat.diff_neg ? S_RAND : S_SLOT;
            end
            S_SLOT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_go)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_go)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mod_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_cnt_reg   <= mod_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* sv/acs_dpath.sv */
// Sequencer datapath: advertising state, delay generator and slot arithmetic.
module acs_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  acs_pkg::acs_cfg_t  cfg,
    input  acs_pkg::acs_req_t  req_data,
    output acs_pkg::acs_rsp_t  rsp_data,
    input  acs_pkg::acs_cmd_t  cmd,
    output acs_pkg::acs_stat_t stat
);
    import acs_pkg::*;

    acs_req_t           in_reg, in_next;
    acs_rsp_t           out_reg, out_next;
    logic               enabled_reg, enabled_next;
    logic               pv_reg, pv_next;
    logic [2:0]         mask_reg, mask_next;
    logic [2:0]         kind_reg, kind_next;
    logic [15:0]        imax_reg, imax_next;
    logic [31:0]        interval_us_reg, interval_us_next;
    logic [5:0]         chan_reg, chan_next;
    logic [31:0]        event_start_reg, event_start_next;
    logic [31:0]        pdu_reg, pdu_next;
    logic [15:0]        lfsr_reg, lfsr_next;
    logic [15:0]        rem_reg, rem_next;
    logic [31:0]        step_reg, step_next;
    logic signed [32:0] delta_reg, delta_next;
    logic [31:0]        slot_start_reg, slot_start_next;
    logic [1:0]         status_reg, status_next;
    logic               sched_reg, sched_next;
    logic               late_reg, late_next;

    logic [15:0]        kind_floor;
    logic               kind_ok;
    logic [5:0]         first_ch;
    logic [5:0]         last_ch;
    logic [5:0]         hop_ch;
    logic [2:0]         hop_off;
    logic [15:0]        gap;
    logic [31:0]        diff;
    logic signed [32:0] delta_sum;
    logic [31:0]        adv_sum;
    logic [31:0]        mod_sub;
    logic [15:0]        lfsr_new;
    logic               is_tx_done;

    assign first_ch   = first_channel(mask_reg);
    assign last_ch    = last_channel(mask_reg);
    assign hop_ch     = chan_reg + 6'd1;
    assign hop_off    = hop_ch[2:0] - FIRST_ADV_CH[2:0];
    assign gap        = ({5'd0, kind_reg} == KIND_DIRECT_HD) ? cfg.high_duty_gap_us
                                                            : cfg.low_duty_gap_us;
    assign diff       = pdu_reg - in_reg.now_time;
    assign adv_sum    = event_start_reg + step_reg;
    assign delta_sum  = delta_reg + $signed({1'b0, step_reg});
    assign mod_sub    = DELAY_DIV << cmd.mod_shift;
    assign lfsr_new   = lfsr_step(lfsr_reg);
    assign is_tx_done = (in_reg.req_type == REQ_TX_DONE) && enabled_reg;

    always_comb
    begin
        stat.need_step = is_tx_done && (chan_reg == last_ch);
        stat.hop       = is_tx_done && (chan_reg != last_ch);
        stat.slot      = (in_reg.req_type == REQ_ENABLE) && (in_reg.enable_code == ENABLE_ON)
                         && !enabled_reg && pv_reg;
        stat.late      = late_reg;
        stat.diff_neg  = diff[31];
        stat.delta_neg = delta_sum[32];
    end

    always_comb
    begin
        case (in_reg.adv_kind) inside
            KIND_IND, KIND_DIRECT_HD, KIND_DIRECT_LD:
            begin
                kind_floor = cfg.conn_interval_floor;
                kind_ok    = 1'b1;
            end
            KIND_SCAN_IND, KIND_NONCONN:
            begin
                kind_floor = cfg.nonconn_interval_floor;
                kind_ok    = 1'b1;
            end
            default:
            begin
                kind_floor = cfg.conn_interval_floor;
                kind_ok    = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        in_next          = in_reg;
        out_next         = out_reg;
        enabled_next     = enabled_reg;
        pv_next          = pv_reg;
        mask_next        = mask_reg;
        kind_next        = kind_reg;
        imax_next        = imax_reg;
        interval_us_next = interval_us_reg;
        chan_next        = chan_reg;
        event_start_next = event_start_reg;
        pdu_next         = pdu_reg;
        lfsr_next        = lfsr_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        delta_next       = delta_reg;
        slot_start_next  = slot_start_reg;
        status_next      = status_reg;
        sched_next       = sched_reg;
        late_next        = late_reg;

        if (cmd.load_in)
            in_next = req_data;

        if (cmd.exec)
        begin
            status_next = STS_SUCCESS;
            sched_next  = 1'b0;
            late_next   = 1'b0;
            unique case (in_reg.req_type)
                REQ_SET_PARAMS:
                begin
                    if (enabled_reg)
                        status_next = STS_DISALLOWED;
                    else
                    begin
                        pv_next     = 1'b0;
                        status_next = STS_INVALID;
                        if ((in_reg.interval_min < in_reg.interval_max) && kind_ok
                            && (in_reg.interval_min >= kind_floor)
                            && (in_reg.interval_min <= cfg.interval_ceiling))
                        begin
                            imax_next = in_reg.interval_max;
                            kind_next = in_reg.adv_kind[2:0];
                            if ((in_reg.own_address_kind <= OWN_ADDR_MAX)
                                && (in_reg.peer_address_kind <= PEER_ADDR_MAX)
                                && ((in_reg.channel_mask_in & MASK_RSVD) == 8'd0)
                                && (in_reg.channel_mask_in != 8'd0))
                            begin
                                mask_next = in_reg.channel_mask_in[2:0];
                                if (in_reg.filter_policy <= FILTER_MAX)
                                begin
                                    pv_next     = 1'b1;
                                    status_next = STS_SUCCESS;
                                end
                            end
                        end
                    end
                end
                REQ_ENABLE:
                begin
                    if (in_reg.enable_code == ENABLE_ON)
                    begin
                        if (!enabled_reg)
                        begin
                            if (pv_reg)
                            begin
                                enabled_next     = 1'b1;
                                interval_us_next = 32'({16'd0, imax_reg} * UNIT_MULT);
                                chan_next        = first_ch;
                                event_start_next = in_reg.now_time;
                                pdu_next         = in_reg.now_time;
                                sched_next       = 1'b1;
                            end
                            else
                                status_next = STS_DISALLOWED;
                        end
                    end
                    else if (in_reg.enable_code == ENABLE_OFF)
                        enabled_next = 1'b0;
                    else
                        status_next = STS_INVALID;
                end
                REQ_TX_DONE:
                begin
                    if (enabled_reg)
                    begin
                        sched_next = 1'b1;
                        if (chan_reg == last_ch)
                            chan_next = first_ch;
                        else
                        begin
                            if ((hop_off > 3'd2) || !mask_reg[hop_off[1:0]])
                                chan_next = hop_ch + 6'd1;
                            else
                                chan_next = hop_ch;
                            pdu_next = pdu_reg + {16'd0, gap};
                        end
                    end
                    else
                        status_next = STS_DISALLOWED;
                end
                default:
                begin
                    status_next = STS_DISALLOWED;
                end
            endcase
        end

        if (cmd.rand_load)
        begin
            lfsr_next = lfsr_new;
            rem_next  = lfsr_new;
        end

        if (cmd.mod_step && ({16'd0, rem_reg} >= mod_sub))
            rem_next = rem_reg - mod_sub[15:0];

        if (cmd.step_calc)
            step_next = interval_us_reg + {16'd0, rem_reg};

        if (cmd.advance)
        begin
            event_start_next = adv_sum;
            pdu_next         = adv_sum;
            delta_next       = delta_sum;
        end

        if (cmd.check && diff[31])
        begin
            late_next  = 1'b1;
            chan_next  = first_ch;
            delta_next = $signed({diff[31], diff});
        end

        if (cmd.slot_calc)
            slot_start_next = pdu_reg - {16'd0, cfg.tx_lead_us};

        if (cmd.emit)
        begin
            out_next.status          = status_reg;
            out_next.sched_valid     = sched_reg;
            out_next.channel         = sched_reg ? chan_reg : 6'd0;
            out_next.slot_start      = sched_reg ? slot_start_reg : 32'd0;
            out_next.slot_end        = sched_reg ? slot_start_reg + {16'd0, cfg.event_window_us}
                                                 : 32'd0;
            out_next.listen_after_tx = sched_reg && ({5'd0, kind_reg} != KIND_NONCONN);
            out_next.was_late        = sched_reg && late_reg;
        end
    end

    assign rsp_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            pv_reg          <= 1'b0;
            mask_reg        <= 3'd0;
            kind_reg        <= 3'd0;
            imax_reg        <= 16'd0;
            interval_us_reg <= 32'd0;
            chan_reg        <= FIRST_ADV_CH;
            event_start_reg <= 32'd0;
            pdu_reg         <= 32'd0;
            lfsr_reg        <= LFSR_SEED;
        end
        else
        begin
            enabled_reg     <= enabled_next;
            pv_reg          <= pv_next;
            mask_reg        <= mask_next;
            kind_reg        <= kind_next;
            imax_reg        <= imax_next;
            interval_us_reg <= interval_us_next;
            chan_reg        <= chan_next;
            event_start_reg <= event_start_next;
            pdu_reg         <= pdu_next;
            lfsr_reg        <= lfsr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg         <= in_next;
        out_reg        <= out_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        delta_reg      <= delta_next;
        slot_start_reg <= slot_start_next;
        status_reg     <= status_next;
        sched_reg      <= sched_next;
        late_reg       <= late_next;
    end

endmodule

/* sim/adv_channel_event_sequencer_tb.sv */
// Self-checking testbench for the advertising channel event sequencer: slot prediction and checks.
`timescale 1ns / 100ps

import acs_pkg::*;

class slot_scoreboard;
    bit [15:0] conn_floor;
    bit [15:0] nonconn_floor;
    bit [15:0] ceiling;
    bit [15:0] hd_gap;
    bit [15:0] ld_gap;
    bit [15:0] tx_lead;
    bit [15:0] window;

    bit        enabled;
    bit        params_ok;
    bit [2:0]  mask;
    bit [2:0]  kind;
    bit [15:0] imax_saved;
    bit [31:0] interval_us;
    bit [5:0]  chan;
    bit [31:0] ev_start;
    bit [31:0] pdu_time;
    bit [15:0] lfsr;

    acs_rsp_t  expected_slots[$];
    int        mismatches;
    int        n_checked;
    int        n_slots;
    int        n_late;
    int        n_refused;

    function new();
        conn_floor    = 16'd32;
        nonconn_floor = 16'd160;
        ceiling       = 16'd16384;
        hd_gap        = 16'd5000;
        ld_gap        = 16'd10000;
        tx_lead       = 16'd0;
        window        = 16'd1228;
        enabled       = 1'b0;
        params_ok     = 1'b0;
        mask          = '0;
        kind          = '0;
        imax_saved    = '0;
        interval_us   = '0;
        chan          = FIRST_ADV_CH;
        ev_start      = '0;
        pdu_time      = '0;
        lfsr          = LFSR_SEED;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [15:0] v);
        case (idx)
            CFG_CONN_FLOOR:    conn_floor = v;
            CFG_NONCONN_FLOOR: nonconn_floor = v;
            CFG_CEILING:       ceiling = v;
            CFG_HD_GAP:        hd_gap = v;
            CFG_LD_GAP:        ld_gap = v;
            CFG_TX_LEAD:       tx_lead = v;
            CFG_EVENT_WINDOW:  window = v;
            default:           ;
        endcase
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    function int pending();
        return expected_slots.size();
    endfunction

    function bit [15:0] lfsr_next(bit [15:0] l);
        return {l[0] ^ l[2] ^ l[3] ^ l[5], l[15:1]};
    endfunction

    function bit [5:0] lowest_ch();
        if (mask[0])
            return FIRST_ADV_CH;
        if (mask[1])
            return FIRST_ADV_CH + 6'd1;
        return FIRST_ADV_CH + 6'd2;
    endfunction

    function bit [5:0] highest_ch();
        if (mask[2])
            return FIRST_ADV_CH + 6'd2;
        if (mask[1])
            return FIRST_ADV_CH + 6'd1;
        return FIRST_ADV_CH;
    endfunction

    function bit [31:0] gap_us();
        return (kind == KIND_DIRECT_HD) ? 32'(hd_gap) : 32'(ld_gap);
    endfunction

    // PDU time the next transmit-done would land on if it came early enough
    function bit [31:0] next_pdu();
        if (chan == highest_ch())
            return ev_start + interval_us + 32'(lfsr_next(lfsr) % MAX_DELAY_US);
        return pdu_time + gap_us();
    endfunction

    function bit [31:0] event_advance();
        lfsr = lfsr_next(lfsr);
        return interval_us + 32'(lfsr % MAX_DELAY_US);
    endfunction

    function bit [1:0] load_params(acs_req_t r);
        bit [15:0] fl;
        if (enabled)
            return STS_DISALLOWED;
        params_ok = 1'b0;
        if (r.interval_min >= r.interval_max)
            return STS_INVALID;
        case (r.adv_kind)
            KIND_IND, KIND_DIRECT_HD, KIND_DIRECT_LD: fl = conn_floor;
            KIND_SCAN_IND, KIND_NONCONN:              fl = nonconn_floor;
            default:                                  return STS_INVALID;
        endcase
        if (r.interval_min < fl || r.interval_min > ceiling)
            return STS_INVALID;
        imax_saved = r.interval_max;
        kind = r.adv_kind[2:0];
        if (r.own_address_kind > OWN_ADDR_MAX || r.peer_address_kind > PEER_ADDR_MAX)
            return STS_INVALID;
        if ((r.channel_mask_in & MASK_RSVD) != 8'd0 || r.channel_mask_in == 8'd0)
            return STS_INVALID;
        mask = r.channel_mask_in[2:0];
        if (r.filter_policy > FILTER_MAX)
            return STS_INVALID;
        params_ok = 1'b1;
        return STS_SUCCESS;
    endfunction

    function acs_rsp_t slot_beat(bit late);
        acs_rsp_t  e;
        bit [31:0] s;
        s = pdu_time - 32'(tx_lead);
        e = '0;
        e.status = STS_SUCCESS;
        e.sched_valid = 1'b1;
        e.channel = chan;
        e.slot_start = s;
        e.slot_end = s + 32'(window);
        e.listen_after_tx = (kind != KIND_NONCONN[2:0]);
        e.was_late = late;
        n_slots++;
        if (late)
            n_late++;
        return e;
    endfunction

    function void take_request(acs_req_t r);
        acs_rsp_t  e;
        bit [31:0] diff;
        bit [31:0] step_us;
        longint    delta;
        int        off;
        e = '0;
        case (r.req_type)
            REQ_SET_PARAMS: e.status = load_params(r);
            REQ_ENABLE:
            begin
                if (r.enable_code == ENABLE_ON) begin
                    if (!enabled) begin
                        if (params_ok) begin
                            enabled = 1'b1;
                            interval_us = 32'(imax_saved) * INTERVAL_UNIT_US;
                            chan = lowest_ch();
                            ev_start = r.now_time;
                            pdu_time = r.now_time;
                            e = slot_beat(1'b0);
                        end
                        else
                            e.status = STS_DISALLOWED;
                    end
                end
                else if (r.enable_code == ENABLE_OFF)
                    enabled = 1'b0;
                else
                    e.status = STS_INVALID;
            end
            REQ_TX_DONE:
            begin
                if (enabled) begin
                    if (chan == highest_ch()) begin
                        chan = lowest_ch();
                        ev_start += event_advance();
                        pdu_time = ev_start;
                    end
                    else begin
                        chan++;
                        off = int'(chan - FIRST_ADV_CH) & 7;
                        if (off > 2 || !mask[off])
                            chan++;
                        pdu_time += gap_us();
                    end
                    diff = pdu_time - r.now_time;
                    delta = longint'($signed(diff));
                    if (delta < 0) begin
                        // skip whole events until the slot lies ahead of now
                        chan = lowest_ch();
                        while (delta < 0) begin
                            step_us = event_advance();
                            ev_start += step_us;
                            pdu_time = ev_start;
                            delta += longint'(step_us);
                        end
                        e = slot_beat(1'b1);
                    end
                    else
                        e = slot_beat(1'b0);
                end
                else
                    e.status = STS_DISALLOWED;
            end
            default: e.status = STS_DISALLOWED;
        endcase
        if (e.status != STS_SUCCESS)
            n_refused++;
        expected_slots.push_back(e);
    endfunction

    function string show(acs_rsp_t r);
        return $sformatf("sts=%0d sched=%0b ch=%0d start=%h end=%h listen=%0b late=%0b",
                         r.status, r.sched_valid, r.channel, r.slot_start, r.slot_end,
                         r.listen_after_tx, r.was_late);
    endfunction

    function void check_reply(acs_rsp_t got);
        acs_rsp_t want;
        if (expected_slots.size() == 0) begin
            flag($sformatf("result with no request pending: %s", show(got)));
            return;
        end
        want = expected_slots.pop_front();
        n_checked++;
        if (got.status !== want.status || got.sched_valid !== want.sched_valid ||
            got.channel !== want.channel || got.slot_start !== want.slot_start ||
            got.slot_end !== want.slot_end || got.listen_after_tx !== want.listen_after_tx ||
            got.was_late !== want.was_late)
            flag($sformatf("result %0d expected %s got %s", n_checked, show(want), show(got)));
    endfunction
endclass

module adv_channel_event_sequencer_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 250;
    localparam int NUM_PHASES     = 7;

    localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
    localparam logic [7:0] ENABLE_BOGUS = 8'hFF;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    acs_req_t              req_data = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    acs_rsp_t              rsp_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    slot_scoreboard sb = new();
    int             n_sent;
    int             burst_left;
    bit             sender_gaps;
    int             stall_pct;

    adv_channel_event_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic acs_req_t random_req();
        acs_req_t r;
        r.req_type          = 2'($urandom);
        r.interval_min      = 16'($urandom);
        r.interval_max      = 16'($urandom);
        r.adv_kind          = 8'($urandom);
        r.own_address_kind  = 8'($urandom);
        r.peer_address_kind = 8'($urandom);
        r.channel_mask_in   = 8'($urandom);
        r.filter_policy     = 8'($urandom);
        r.enable_code       = 8'($urandom);
        r.now_time          = $urandom;
        return r;
    endfunction

    function automatic acs_req_t params_item(logic [7:0] kind, logic [15:0] imin,
                                             logic [15:0] imax, logic [7:0] own,
                                             logic [7:0] peer, logic [7:0] mask,
                                             logic [7:0] filt);
        acs_req_t r;
        r = random_req();
        r.req_type          = REQ_SET_PARAMS;
        r.adv_kind          = kind;
        r.interval_min      = imin;
        r.interval_max      = imax;
        r.own_address_kind  = own;
        r.peer_address_kind = peer;
        r.channel_mask_in   = mask;
        r.filter_policy     = filt;
        return r;
    endfunction

    function automatic acs_req_t valid_params(bit corrupt);
        acs_req_t   r;
        logic [7:0] kind;
        int         fl;
        int         top;
        int         imin;
        int         imax;
        int         hi;
        kind = 8'($urandom_range(KIND_DIRECT_LD, KIND_IND));
        fl = (kind == KIND_SCAN_IND || kind == KIND_NONCONN) ? sb.nonconn_floor : sb.conn_floor;
        top = (sb.ceiling < 16'hFFFE) ? sb.ceiling : 16'hFFFE;
        if (fl <= top)
            imin = $urandom_range(top, fl);
        else
            imin = $urandom_range(16'hFFFF, 0);
        hi = $urandom_range(0, 1) ? 16'hFFFF : imin + 64;
        if (hi > 16'hFFFF)
            hi = 16'hFFFF;
        if (imin < 16'hFFFF)
            imax = $urandom_range(hi, imin + 1);
        else
            imax = imin;
        r = params_item(kind, 16'(imin), 16'(imax), 8'($urandom_range(OWN_ADDR_MAX, 0)),
                        8'($urandom_range(PEER_ADDR_MAX, 0)), 8'($urandom_range(7, 1)),
                        8'($urandom_range(FILTER_MAX, 0)));
        if (corrupt) begin
            case ($urandom_range(0, 7))
                0: r.interval_max = r.interval_min;
                1: r.adv_kind = 8'($urandom_range(255, KIND_DIRECT_LD + 1));
                2: r.interval_min = 16'($urandom_range(fl, 0)) - 16'd1;
                3: r.interval_min = sb.ceiling + 16'd1;
                4: r.own_address_kind = 8'($urandom_range(255, OWN_ADDR_MAX + 1));
                5: r.peer_address_kind = 8'($urandom_range(255, PEER_ADDR_MAX + 1));
                6: r.channel_mask_in = $urandom_range(0, 1) ? 8'd0 : {5'($urandom), 3'($urandom)};
                default: r.filter_policy = 8'($urandom_range(255, FILTER_MAX + 1));
            endcase
        end
        return r;
    endfunction

    function automatic acs_req_t enable_item(logic [7:0] code, logic [31:0] now);
        acs_req_t r;
        r = random_req();
        r.req_type    = REQ_ENABLE;
        r.enable_code = code;
        r.now_time    = now;
        return r;
    endfunction

    function automatic acs_req_t hop_at(int off);
        acs_req_t r;
        r = random_req();
        r.req_type = REQ_TX_DONE;
        r.now_time = sb.next_pdu() + 32'(off);
        return r;
    endfunction

    function automatic acs_req_t hop_item();
        int off;
        case ($urandom_range(0, 19))
            0: off = 0;
            1: off = 1;
            2: off = -1;
            3, 4: off = $urandom_range(1, 3 * (sb.interval_us + MAX_DELAY_US));
            5: off = -int'($urandom_range(32'h7FF0_0000, 32'h0010_0000));
            default: off = -int'($urandom_range(50000, 0));
        endcase
        return hop_at(off);
    endfunction

    function automatic acs_req_t noise_item();
        acs_req_t r;
        r = random_req();
        if ($urandom_range(0, 1))
            r.enable_code = 8'($urandom_range(0, 2));
        // keep catch-up bounded: a live schedule never sees a wild now
        if (r.req_type == REQ_TX_DONE && sb.enabled)
            r = hop_item();
        return r;
    endfunction

    task automatic send(acs_req_t r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps) begin
                req_valid <= 1'b0;
                repeat ($urandom_range(0, 7) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 6))
                    @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_stall);
        sb.take_request(r);
        n_sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(cfg_idx_t idx, logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 4);
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, v);
        // read back through the same port
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {16'h0000, v})
            sb.flag($sformatf("register %s read %h, wrote %h", idx.name(), prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int  hold;
        bit  held;
        hold = 0;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                sb.check_reply(rsp_data);
            if (hold > 0) begin
                hold--;
                rsp_stall <= 1'b1;
            end
            else if (!held && sb.n_checked >= HOLD_AFTER) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("adv_channel_event_sequencer test failed");
        $finish;
    end

    initial
    begin
        acs_req_t    r;
        logic [15:0] regs [NUM_CFG];
        int          phase_items [NUM_PHASES];
        int          sel;
        n_sent      = 0;
        burst_left  = 0;
        sender_gaps = 1'b0;
        stall_pct   = 0;
        phase_items = '{150, 150, 40, 160, 160, 160, 160};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: refusals, every parameter check, hops, wrap and catch-up
        send(hop_at(0));
        r = random_req();
        r.req_type = REQ_UNKNOWN;
        send(r);
        send(enable_item(ENABLE_ON, $urandom));
        send(enable_item(ENABLE_BOGUS, $urandom));
        send(enable_item(ENABLE_OFF, $urandom));
        send(params_item(KIND_IND, 16'd100, 16'd100, 8'd0, 8'd0, 8'd1, 8'd0));
        send(params_item(KIND_DIRECT_LD + 8'd1, 16'd100, 16'd200, 8'd0, 8'd0, 8'd1, 8'd0));
        send(params_item(KIND_SCAN_IND, 16'd159, 16'd300, 8'd0, 8'd0, 8'd1, 8'd0));
        send(params_item(KIND_IND, 16'd16385, 16'd16400, 8'd0, 8'd0, 8'd1, 8'd0));
        send(params_item(KIND_IND, 16'd32, 16'd64, OWN_ADDR_MAX + 8'd1, 8'd0, 8'd7, 8'd0));
        send(params_item(KIND_IND, 16'd32, 16'd64, 8'd0, PEER_ADDR_MAX + 8'd1, 8'd7, 8'd0));
        send(params_item(KIND_IND, 16'd32, 16'd64, 8'd0, 8'd0, 8'd0, 8'd0));
        send(params_item(KIND_IND, 16'd32, 16'd64, 8'd0, 8'd0, 8'h09, 8'd0));
        send(params_item(KIND_IND, 16'd32, 16'd64, 8'd0, 8'd0, 8'd7, FILTER_MAX + 8'd1));
        send(params_item(KIND_DIRECT_HD, 16'd32, 16'hFFFF, OWN_ADDR_MAX, PEER_ADDR_MAX,
                         8'h05, FILTER_MAX));
        send(enable_item(ENABLE_ON, 32'hFFFF_F000));
        send(params_item(KIND_IND, 16'd32, 16'd64, 8'd0, 8'd0, 8'd1, 8'd0));
        send(enable_item(ENABLE_ON, $urandom));
        send(hop_at(0));
        send(hop_at(0));
        send(hop_at(1));
        send(hop_at(-1));
        send(enable_item(ENABLE_OFF, $urandom));
        send(params_item(KIND_NONCONN, 16'd160, 16'd161, 8'd0, 8'd0, 8'h02, 8'd0));
        send(enable_item(ENABLE_ON, 32'd0));
        send(hop_at(3 * int'(sb.interval_us)));
        send(enable_item(ENABLE_OFF, $urandom));
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: regs = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
                1: regs = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: regs = '{16'hFFFF, 16'hFFFF, 16'd0, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom)};
                default: regs = '{16'($urandom_range(400, 0)), 16'($urandom_range(800, 0)),
                                  16'($urandom_range(16'hFFFF, 1000)), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom)};
            endcase
            for (int i = 0; i < NUM_CFG; i++)
                reg_write(cfg_idx_t'(i), regs[i]);
            sender_gaps = (ph != 0 && ph != 4);
            stall_pct   = (ph == 0) ? 0 : $urandom_range(70, 5);
            burst_left  = 0;

            for (int i = 0; i < phase_items[ph]; i++) begin
                sel = $urandom_range(0, 39);
                if (!sb.enabled) begin
                    if (sel < 4)
                        r = noise_item();
                    else if (sel < 8)
                        r = valid_params(1'b1);
                    else if (sel < 14 || !sb.params_ok)
                        r = valid_params(1'b0);
                    else
                        r = enable_item(ENABLE_ON, $urandom);
                end
                else begin
                    if (sel == 0)
                        r = enable_item(ENABLE_OFF, $urandom);
                    else if (sel < 3)
                        r = noise_item();
                    else if (sel == 3)
                        r = enable_item(ENABLE_ON, $urandom);
                    else
                        r = hop_item();
                end
                send(r);
            end
            drain();
        end

        $display("Sent %0d requests over %0d register settings; checked %0d results.",
                 n_sent, NUM_PHASES + 1, sb.n_checked);
        $display("Scheduled %0d slots (%0d after catch-up), %0d requests refused.",
                 sb.n_slots, sb.n_late, sb.n_refused);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("adv_channel_event_sequencer test passed");
        else
            $display("adv_channel_event_sequencer test failed");
        $finish;
    end

endmodule

/* files.f */
sv/acs_pkg.sv
sv/acs_cfg.sv
sv/acs_ctrl.sv
sv/acs_dpath.sv
sv/adv_channel_event_sequencer.sv
sim/adv_channel_event_sequencer_tb.sv
